FILE: rtl/core/assert_macros.svh
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is held.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: rtl/core/twrsm_pkg.sv
package twrsm_pkg;

    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 16;
    localparam int CMD_W      = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // result beat bit positions
    localparam int OB_EN    = 0;
    localparam int OB_CLK   = 1;
    localparam int OB_DOUT  = 2;
    localparam int OB_DRIVE = 3;
    localparam int OB_BUSY  = 4;
    localparam int OB_DONE  = 5;
    localparam int OB_RDLO  = 6;
    localparam int OB_RDHI  = 13;

    localparam logic [CMD_W-1:0] CMD_TICK  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_WRITE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_PHASE_TICKS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WRAP        = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CTRL_ADDR   = 2'd2;

    localparam logic [15:0] RST_PHASE_TICKS = 16'd2;
    localparam logic        RST_WRAP        = 1'b1;
    localparam logic [7:0]  RST_CTRL_ADDR   = 8'd142;

    localparam logic [7:0] CTRL_PROTECT_OFF = 8'h00;
    localparam logic [7:0] CTRL_PROTECT_ON  = 8'h80;

    localparam logic [1:0] FS_PROT_OFF = 2'd0;
    localparam logic [1:0] FS_WRAPPED  = 2'd1;
    localparam logic [1:0] FS_PROT_ON  = 2'd2;
    localparam logic [1:0] FS_SINGLE   = 2'd3;

endpackage

FILE: rtl/core/three_wire_rtc_serial_master.sv
// Channel  | Dir | Beat contents
// s_*      | in  | tuser: cmd; tdata: reg_address, write_byte, data_pin_in
// m_*      | out | tdata: pin levels, busy, done, read_byte
// cfg_*    | in  | register index and write data, taken when write enable high
//
// One input beat is one bus time tick; every cycle can take one unless the result register is stalled.
// The result of a beat is written into the output register on acceptance.
// While that register is full and not taken, o_s_tready is low.
// Reset (i_rst_n low, synchronous) idles the sequencer and restores the
// register defaults.
module three_wire_rtc_serial_master (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_s_tvalid,
    output logic                                 o_s_tready,
    // [7:0] reg_address, [15:8] write_byte, [16] data_pin_in
    input  logic [twrsm_pkg::IN_DATA_W-1:0]      i_s_tdata,
    // [1:0] cmd
    input  logic [twrsm_pkg::CMD_W-1:0]          i_s_tuser,
    output logic                                 o_m_tvalid,
    input  logic                                 i_m_tready,
    // [0] enable_pin, [1] clock_pin, [2] data_pin_out, [3] data_pin_drive,
    // [4] busy_res, [5] done_res, [13:6] read_byte
    output logic [twrsm_pkg::OUT_DATA_W-1:0]     o_m_tdata,
    input  logic                                 i_cfg_we,
    input  logic [twrsm_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [twrsm_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    localparam logic [3:0] PH_IDLE   = 4'd0;
    localparam logic [3:0] PH_SETTLE = 4'd1;
    localparam logic [3:0] PH_LOW1   = 4'd2;
    localparam logic [3:0] PH_LOW2   = 4'd3;
    localparam logic [3:0] PH_HIGH   = 4'd4;
    localparam logic [3:0] PH_GAP    = 4'd5;
    localparam logic [3:0] PH_END    = 4'd6;

    logic [15:0] r_phase_ticks;
    logic        r_wrap;
    logic [7:0]  r_ctrl_addr;

    logic [3:0]  r_phase,     n_phase;
    logic [15:0] r_tick,      n_tick;
    logic [2:0]  r_bit,       n_bit;
    logic        r_byte,      n_byte;
    logic [1:0]  r_frame,     n_frame;
    logic [7:0]  r_out_shift, n_out_shift;
    logic [7:0]  r_in_shift,  n_in_shift;
    logic [7:0]  r_held_addr, n_held_addr;
    logic [7:0]  r_held_data, n_held_data;
    logic        r_is_read,   n_is_read;

    logic                               r_m_tvalid;
    logic [twrsm_pkg::OUT_DATA_W-1:0]   r_m_tdata, n_m_tdata;

    logic [twrsm_pkg::CMD_W-1:0] s_cmd;
    logic [7:0]  s_addr;
    logic [7:0]  s_wbyte;
    logic        s_pin;
    logic        w_accept;
    logic [15:0] w_limit;
    logic [15:0] w_tick_inc;
    logic        w_last;
    logic        w_free;
    logic        w_reading;
    logic [7:0]  w_cmd_addr;
    logic [7:0]  w_cmd_byte;
    logic [7:0]  w_data_byte;
    logic        w_done;
    logic        w_releasing;
    logic        w_en;
    logic        w_clk;
    logic        w_drive;

    assign s_cmd   = i_s_tuser;
    assign s_addr  = i_s_tdata[7:0];
    assign s_wbyte = i_s_tdata[15:8];
    assign s_pin   = i_s_tdata[16];

    assign o_s_tready = !r_m_tvalid || i_m_tready;
    assign w_accept   = i_s_tvalid && o_s_tready;
    assign o_m_tvalid = r_m_tvalid;
    assign o_m_tdata  = r_m_tdata;

    assign w_limit    = (r_phase_ticks == 16'd0) ? 16'd1 : r_phase_ticks;
    assign w_tick_inc = r_tick + 16'd1;
    assign w_last     = (r_frame == twrsm_pkg::FS_PROT_ON) ||
                        (r_frame == twrsm_pkg::FS_SINGLE);
    assign w_free     = (r_phase == PH_IDLE) || (r_phase > PH_END) ||
                        ((r_phase == PH_END) && w_last);
    assign w_reading  = r_is_read && r_byte;
    assign w_cmd_addr = ((r_frame == twrsm_pkg::FS_WRAPPED) ||
                         (r_frame == twrsm_pkg::FS_SINGLE)) ? r_held_addr : r_ctrl_addr;
    assign w_cmd_byte = r_is_read ? (w_cmd_addr | 8'h01) : (w_cmd_addr & 8'hFE);

    always_comb begin
        if (r_is_read) begin
            w_data_byte = 8'h00;
        end else if (r_frame == twrsm_pkg::FS_PROT_OFF) begin
            w_data_byte = twrsm_pkg::CTRL_PROTECT_OFF;
        end else if (r_frame == twrsm_pkg::FS_PROT_ON) begin
            w_data_byte = twrsm_pkg::CTRL_PROTECT_ON;
        end else begin
            w_data_byte = r_held_data;
        end
    end

    always_comb begin
        n_phase     = r_phase;
        n_tick      = r_tick;
        n_bit       = r_bit;
        n_byte      = r_byte;
        n_frame     = r_frame;
        n_out_shift = r_out_shift;
        n_in_shift  = r_in_shift;
        n_held_addr = r_held_addr;
        n_held_data = r_held_data;
        n_is_read   = r_is_read;
        if (w_free) begin
            if ((s_cmd == twrsm_pkg::CMD_WRITE) || (s_cmd == twrsm_pkg::CMD_READ)) begin
                n_held_addr = s_addr;
                n_is_read   = (s_cmd == twrsm_pkg::CMD_READ);
                if (s_cmd == twrsm_pkg::CMD_WRITE) begin
                    n_held_data = s_wbyte;
                end
                n_frame = ((s_cmd == twrsm_pkg::CMD_WRITE) && r_wrap) ?
                          twrsm_pkg::FS_PROT_OFF : twrsm_pkg::FS_SINGLE;
                n_byte  = 1'b0;
                n_bit   = 3'd0;
                n_phase = PH_SETTLE;
                n_tick  = 16'd0;
            end else begin
                n_phase = PH_IDLE;
            end
        end else if (r_phase == PH_END) begin
            n_frame = r_frame + 2'd1;
            n_byte  = 1'b0;
            n_bit   = 3'd0;
            n_phase = PH_SETTLE;
            n_tick  = 16'd0;
        end else begin
            n_tick = w_tick_inc;
            if (w_tick_inc >= w_limit) begin
                n_tick = 16'd0;
                unique case (r_phase)
                    PH_SETTLE: begin
                        n_byte      = 1'b0;
                        n_bit       = 3'd0;
                        n_out_shift = w_cmd_byte;
                        n_phase     = PH_LOW1;
                    end
                    PH_LOW1: begin
                        if (w_reading) begin
                            n_out_shift = {s_pin, r_out_shift[7:1]};
                        end
                        n_phase = PH_LOW2;
                    end
                    PH_LOW2: begin
                        n_phase = PH_HIGH;
                    end
                    PH_HIGH: begin
                        if (r_bit == 3'd7) begin
                            n_phase = PH_GAP;
                        end else begin
                            if (!w_reading) begin
                                n_out_shift = {1'b0, r_out_shift[7:1]};
                            end
                            n_bit   = r_bit + 3'd1;
                            n_phase = PH_LOW1;
                        end
                    end
                    PH_GAP: begin
                        if (!r_byte) begin
                            n_byte      = 1'b1;
                            n_bit       = 3'd0;
                            n_out_shift = w_data_byte;
                            n_phase     = PH_LOW1;
                        end else begin
                            if (r_is_read) begin
                                n_in_shift = r_out_shift;
                            end
                            n_phase = PH_END;
                        end
                    end
                    default: begin
                        n_phase = PH_IDLE;
                    end
                endcase
            end
        end
    end

    // pins reflect the state after this tick
    always_comb begin
        w_done      = (n_phase == PH_END) &&
                      ((n_frame == twrsm_pkg::FS_PROT_ON) ||
                       (n_frame == twrsm_pkg::FS_SINGLE));
        w_releasing = n_is_read && n_byte;
        if ((n_phase == PH_IDLE) || (n_phase == PH_SETTLE)) begin
            w_en    = 1'b0;
            w_clk   = 1'b0;
            w_drive = 1'b0;
        end else begin
            w_en    = (n_phase != PH_END);
            w_clk   = (n_phase == PH_HIGH) || (n_phase == PH_GAP) || (n_phase == PH_END);
            w_drive = !w_releasing;
        end
        n_m_tdata = '0;
        n_m_tdata[twrsm_pkg::OB_EN]    = w_en;
        n_m_tdata[twrsm_pkg::OB_CLK]   = w_clk;
        n_m_tdata[twrsm_pkg::OB_DOUT]  = w_drive && n_out_shift[0];
        n_m_tdata[twrsm_pkg::OB_DRIVE] = w_drive;
        n_m_tdata[twrsm_pkg::OB_BUSY]  = (n_phase != PH_IDLE) && !w_done;
        n_m_tdata[twrsm_pkg::OB_DONE]  = w_done;
        n_m_tdata[twrsm_pkg::OB_RDHI:twrsm_pkg::OB_RDLO] = n_in_shift;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_ticks <= twrsm_pkg::RST_PHASE_TICKS;
            r_wrap        <= twrsm_pkg::RST_WRAP;
            r_ctrl_addr   <= twrsm_pkg::RST_CTRL_ADDR;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                twrsm_pkg::CFG_PHASE_TICKS: r_phase_ticks <= i_cfg_data;
                twrsm_pkg::CFG_WRAP:        r_wrap        <= i_cfg_data[0];
                twrsm_pkg::CFG_CTRL_ADDR:   r_ctrl_addr   <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_tick      <= 16'd0;
            r_bit       <= 3'd0;
            r_byte      <= 1'b0;
            r_frame     <= twrsm_pkg::FS_PROT_OFF;
            r_out_shift <= 8'd0;
            r_in_shift  <= 8'd0;
            r_held_addr <= 8'd0;
            r_held_data <= 8'd0;
            r_is_read   <= 1'b0;
        end else if (w_accept) begin
            r_phase     <= n_phase;
            r_tick      <= n_tick;
            r_bit       <= n_bit;
            r_byte      <= n_byte;
            r_frame     <= n_frame;
            r_out_shift <= n_out_shift;
            r_in_shift  <= n_in_shift;
            r_held_addr <= n_held_addr;
            r_held_data <= n_held_data;
            r_is_read   <= n_is_read;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_tvalid <= 1'b0;
        end else if (w_accept) begin
            r_m_tvalid <= 1'b1;
        end else if (i_m_tready) begin
            r_m_tvalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_m_tdata <= n_m_tdata;
        end
    end

endmodule

FILE: rtl/core/twrsm_checker.sv
`include "assert_macros.svh"

module twrsm_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_s_tvalid,
    input logic                              o_s_tready,
    input logic                              o_m_tvalid,
    input logic                              i_m_tready,
    input logic [twrsm_pkg::OUT_DATA_W-1:0]  o_m_tdata
);

    // a stalled result keeps its slot
    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_m_tvalid && !i_m_tready, o_m_tvalid)
    // every accepted beat yields a result next cycle
    `ASSERT_NEXT(a_in_to_out, i_clk, i_rst_n, i_s_tvalid && o_s_tready, o_m_tvalid)
    // no beat taken while a result is stuck
    `ASSERT_IMPL(a_stall_blocks, i_clk, i_rst_n, o_m_tvalid && !i_m_tready, !o_s_tready)
    // done ends busy
    `ASSERT_IMPL(a_done_not_busy, i_clk, i_rst_n,
        o_m_tvalid && o_m_tdata[twrsm_pkg::OB_DONE], !o_m_tdata[twrsm_pkg::OB_BUSY])

endmodule

bind three_wire_rtc_serial_master twrsm_checker u_twrsm_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);

FILE: test/three_wire_rtc_serial_master_tb.sv
module three_wire_rtc_serial_master_tb;

    localparam logic [twrsm_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam logic [7:0]                  STALL_MASK = 8'b1011_0110;

    typedef enum logic [3:0] {
        SQ_IDLE, SQ_SETTLE, SQ_LOW1, SQ_LOW2, SQ_HIGH, SQ_GAP, SQ_END
    } t_seq_state;

    typedef enum logic [1:0] {RDY_ALWAYS, RDY_RANDOM, RDY_MASK, RDY_SPARSE} t_rdy_mode;

    typedef struct packed {
        logic       en;
        logic       clk;
        logic       dout;
        logic       drive;
        logic       busy;
        logic       done;
        logic [7:0] rbyte;
    } t_pins;

    typedef struct {
        logic [twrsm_pkg::CMD_W-1:0] cmd;
        logic [7:0]                  addr;
        logic [7:0]                  wb;
        logic                        pin;
        int                          reps;
        bit                          typed;
        t_pins                       exp;
    } t_row;

    localparam t_pins PINS_IDLE   = '0;
    localparam t_pins PINS_SETTLE = '{1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 8'h00};

    logic                              i_clk = 1'b0;
    logic                              i_rst_n = 1'b0;
    logic                              i_s_tvalid = 1'b0;
    logic                              o_s_tready;
    logic [twrsm_pkg::IN_DATA_W-1:0]   i_s_tdata = '0;
    logic [twrsm_pkg::CMD_W-1:0]       i_s_tuser = twrsm_pkg::CMD_TICK;
    logic                              o_m_tvalid;
    logic                              i_m_tready = 1'b0;
    logic [twrsm_pkg::OUT_DATA_W-1:0]  o_m_tdata;
    logic                              i_cfg_we = 1'b0;
    logic [twrsm_pkg::CFG_IDX_W-1:0]   i_cfg_idx = twrsm_pkg::CFG_PHASE_TICKS;
    logic [twrsm_pkg::CFG_DATA_W-1:0]  i_cfg_data = '0;

    three_wire_rtc_serial_master u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // bus sequencer mirror
    logic [15:0] cfg_ticks = twrsm_pkg::RST_PHASE_TICKS;
    logic        cfg_wrap  = twrsm_pkg::RST_WRAP;
    logic [7:0]  cfg_ctrl  = twrsm_pkg::RST_CTRL_ADDR;
    t_seq_state  sq        = SQ_IDLE;
    logic [15:0] tcount    = '0;
    logic [2:0]  bit_no    = '0;
    logic        byte_sel  = 1'b0;
    logic [1:0]  fstep     = twrsm_pkg::FS_PROT_OFF;
    logic [7:0]  shreg     = '0;
    logic [7:0]  rd_byte   = '0;
    logic [7:0]  h_addr    = '0;
    logic [7:0]  h_data    = '0;
    logic        rd_acc    = 1'b0;

    t_pins pin_levels_q[$];
    t_pins got, want, pred;
    bit    in_fire = 1'b0;
    bit    row_typed = 1'b0;
    t_pins row_exp = '0;
    int    err_count = 0;
    int    n_items = 0, n_results = 0, n_writes = 0, n_reads = 0, n_done = 0;
    int    n_refused = 0;
    int    burst_left = 0;

    t_rdy_mode   rdy_mode = RDY_ALWAYS;
    logic [31:0] rdy_cyc = '0;

    function automatic t_pins bus_step(input logic [twrsm_pkg::CMD_W-1:0] cmd,
                                       input logic [7:0] addr,
                                       input logic [7:0] wb, input logic pin);
        logic [15:0] lim;
        logic [7:0]  a;
        logic        free_now, reading, done, drive;
        t_pins       r;
        lim = (cfg_ticks == 16'd0) ? 16'd1 : cfg_ticks;
        free_now = (sq == SQ_IDLE) ||
                   (sq == SQ_END && (fstep == twrsm_pkg::FS_PROT_ON ||
                                     fstep == twrsm_pkg::FS_SINGLE));
        if (free_now) begin
            if (cmd == twrsm_pkg::CMD_WRITE || cmd == twrsm_pkg::CMD_READ) begin
                h_addr = addr;
                rd_acc = (cmd == twrsm_pkg::CMD_READ);
                if (cmd == twrsm_pkg::CMD_WRITE) begin
                    h_data = wb;
                    n_writes++;
                end else begin
                    n_reads++;
                end
                fstep = (cmd == twrsm_pkg::CMD_WRITE && cfg_wrap) ?
                        twrsm_pkg::FS_PROT_OFF : twrsm_pkg::FS_SINGLE;
                byte_sel = 1'b0;
                bit_no = '0;
                sq = SQ_SETTLE;
                tcount = '0;
            end else begin
                sq = SQ_IDLE;
            end
        end else if (sq == SQ_END) begin
            fstep = fstep + 2'd1;
            byte_sel = 1'b0;
            bit_no = '0;
            sq = SQ_SETTLE;
            tcount = '0;
        end else begin
            if (cmd == twrsm_pkg::CMD_WRITE || cmd == twrsm_pkg::CMD_READ)
                n_refused++;
            tcount = tcount + 16'd1;
            if (tcount >= lim) begin
                tcount = '0;
                reading = rd_acc && byte_sel;
                case (sq)
                    SQ_SETTLE: begin
                        byte_sel = 1'b0;
                        bit_no = '0;
                        a = (fstep == twrsm_pkg::FS_WRAPPED || fstep == twrsm_pkg::FS_SINGLE) ?
                            h_addr : cfg_ctrl;
                        shreg = rd_acc ? (a | 8'h01) : (a & 8'hFE);
                        sq = SQ_LOW1;
                    end
                    SQ_LOW1: begin
                        if (reading)
                            shreg = {pin, shreg[7:1]};
                        sq = SQ_LOW2;
                    end
                    SQ_LOW2: sq = SQ_HIGH;
                    SQ_HIGH: begin
                        if (bit_no == 3'd7) begin
                            sq = SQ_GAP;
                        end else begin
                            if (!reading)
                                shreg = shreg >> 1;
                            bit_no = bit_no + 3'd1;
                            sq = SQ_LOW1;
                        end
                    end
                    SQ_GAP: begin
                        if (!byte_sel) begin
                            byte_sel = 1'b1;
                            bit_no = '0;
                            if (rd_acc)
                                shreg = 8'h00;
                            else if (fstep == twrsm_pkg::FS_PROT_OFF)
                                shreg = twrsm_pkg::CTRL_PROTECT_OFF;
                            else if (fstep == twrsm_pkg::FS_PROT_ON)
                                shreg = twrsm_pkg::CTRL_PROTECT_ON;
                            else
                                shreg = h_data;
                            sq = SQ_LOW1;
                        end else begin
                            if (rd_acc)
                                rd_byte = shreg;
                            sq = SQ_END;
                        end
                    end
                    default: sq = SQ_IDLE;
                endcase
            end
        end

        done = (sq == SQ_END) &&
               (fstep == twrsm_pkg::FS_PROT_ON || fstep == twrsm_pkg::FS_SINGLE);
        if (done)
            n_done++;
        reading = rd_acc && byte_sel;
        if (sq == SQ_IDLE || sq == SQ_SETTLE) begin
            r.en = 1'b0;
            r.clk = 1'b0;
            drive = 1'b0;
        end else begin
            r.en = (sq != SQ_END);
            r.clk = (sq == SQ_HIGH || sq == SQ_GAP || sq == SQ_END);
            drive = !reading;
        end
        r.dout = drive & shreg[0];
        r.drive = drive;
        r.busy = (sq != SQ_IDLE) && !done;
        r.done = done;
        r.rbyte = rd_byte;
        return r;
    endfunction

    task automatic check_field(input string name, input int exp_v, input int got_v);
        if (exp_v != got_v) begin
            $error("%s: expected %0d, got %0d", name, exp_v, got_v);
            err_count++;
        end
    endtask

    // beats sampled mid-cycle: values are those seen at the next rising edge
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (o_m_tvalid && i_m_tready) begin
                n_results++;
                got.en    = o_m_tdata[twrsm_pkg::OB_EN];
                got.clk   = o_m_tdata[twrsm_pkg::OB_CLK];
                got.dout  = o_m_tdata[twrsm_pkg::OB_DOUT];
                got.drive = o_m_tdata[twrsm_pkg::OB_DRIVE];
                got.busy  = o_m_tdata[twrsm_pkg::OB_BUSY];
                got.done  = o_m_tdata[twrsm_pkg::OB_DONE];
                got.rbyte = o_m_tdata[twrsm_pkg::OB_RDHI:twrsm_pkg::OB_RDLO];
                if (pin_levels_q.size() == 0) begin
                    $error("result beat with nothing expected: %h", o_m_tdata);
                    err_count++;
                end else begin
                    want = pin_levels_q.pop_front();
                    check_field("enable_pin", want.en, got.en);
                    check_field("clock_pin", want.clk, got.clk);
                    check_field("data_pin_out", want.dout, got.dout);
                    check_field("data_pin_drive", want.drive, got.drive);
                    check_field("busy_res", want.busy, got.busy);
                    check_field("done_res", want.done, got.done);
                    check_field("read_byte", want.rbyte, got.rbyte);
                end
            end
            in_fire = i_s_tvalid && o_s_tready;
            if (in_fire) begin
                n_items++;
                pred = bus_step(i_s_tuser, i_s_tdata[7:0], i_s_tdata[15:8], i_s_tdata[16]);
                pin_levels_q.push_back(row_typed ? row_exp : pred);
            end
        end else begin
            in_fire = 1'b0;
        end
    end

    always @(posedge i_clk) begin
        rdy_cyc <= rdy_cyc + 32'd1;
        if (rdy_cyc % 160 == 0)
            rdy_mode <= t_rdy_mode'($urandom_range(0, 3));
        case (rdy_mode)
            RDY_ALWAYS: i_m_tready <= 1'b1;
            RDY_RANDOM: i_m_tready <= ($urandom_range(0, 3) != 0);
            RDY_MASK:   i_m_tready <= STALL_MASK[rdy_cyc[2:0]];
            default:    i_m_tready <= (rdy_cyc % 19) < 2;
        endcase
    end

    task automatic send(input logic [twrsm_pkg::CMD_W-1:0] cmd, input logic [7:0] addr,
                        input logic [7:0] wb, input logic pin,
                        input bit typed, input t_pins exp);
        if (burst_left == 0) begin
            i_s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 12);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= cmd;
        i_s_tdata  <= {7'd0, pin, wb, addr};
        row_typed  <= typed;
        row_exp    <= exp;
        do @(posedge i_clk); while (!in_fire);
        burst_left--;
    endtask

    task automatic drain();
        i_s_tvalid <= 1'b0;
        do @(posedge i_clk); while (pin_levels_q.size() != 0);
    endtask

    task automatic cfg_write(input logic [twrsm_pkg::CFG_IDX_W-1:0] idx,
                             input logic [15:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        case (idx)
            twrsm_pkg::CFG_PHASE_TICKS: cfg_ticks = val;
            twrsm_pkg::CFG_WRAP:        cfg_wrap  = val[0];
            twrsm_pkg::CFG_CTRL_ADDR:   cfg_ctrl  = val[7:0];
            default: ;
        endcase
    endtask

    task automatic set_config(input logic [15:0] ticks, input logic wrap,
                              input logic [7:0] ctrl);
        drain();
        cfg_write(twrsm_pkg::CFG_PHASE_TICKS, ticks);
        cfg_write(twrsm_pkg::CFG_WRAP, {15'd0, wrap});
        cfg_write(twrsm_pkg::CFG_CTRL_ADDR, {8'd0, ctrl});
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 7))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic send_ticks(input int n);
        logic [twrsm_pkg::CMD_W-1:0] c;
        repeat (n) begin
            c = ($urandom_range(0, 11) == 0) ? twrsm_pkg::CMD_W'($urandom_range(0, 3))
                                             : twrsm_pkg::CMD_TICK;
            send(c, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                 1'($urandom_range(0, 1)), 1'b0, PINS_IDLE);
        end
    endtask

    // mostly complete accesses back to back, some cut short or padded
    task automatic random_accesses(input int budget);
        int  sent, lim, frames, n;
        bit  is_rd;
        sent = 0;
        while (sent < budget) begin
            if ($urandom_range(0, 9) == 0)
                drain();
            is_rd = 1'($urandom_range(0, 1));
            send(is_rd ? twrsm_pkg::CMD_READ : twrsm_pkg::CMD_WRITE, pick_byte(), pick_byte(),
                 1'($urandom_range(0, 1)), 1'b0, PINS_IDLE);
            lim = (cfg_ticks == 16'd0) ? 1 : int'(cfg_ticks);
            frames = (!is_rd && cfg_wrap) ? 3 : 1;
            n = frames * (51 * lim + 1) - 1;
            case ($urandom_range(0, 9))
                0:       n = $urandom_range(1, n);
                1, 2:    n = n + $urandom_range(1, 4);
                default: ;
            endcase
            send_ticks(n);
            sent = sent + n + 1;
        end
    endtask

    t_row dir_rows [11] = '{
        '{twrsm_pkg::CMD_TICK,  8'h00, 8'h00, 1'b0, 1,   1'b1, PINS_IDLE},
        '{CMD_UNUSED,           8'hFF, 8'hFF, 1'b1, 1,   1'b1, PINS_IDLE},
        '{twrsm_pkg::CMD_WRITE, 8'hFF, 8'h00, 1'b0, 1,   1'b1, PINS_SETTLE},
        '{twrsm_pkg::CMD_READ,  8'h00, 8'h00, 1'b1, 1,   1'b0, PINS_IDLE},
        '{twrsm_pkg::CMD_TICK,  8'h00, 8'h00, 1'b1, 307, 1'b0, PINS_IDLE},
        '{twrsm_pkg::CMD_READ,  8'h00, 8'hFF, 1'b0, 1,   1'b0, PINS_IDLE},
        '{twrsm_pkg::CMD_TICK,  8'hFF, 8'hFF, 1'b1, 102, 1'b0, PINS_IDLE},
        '{twrsm_pkg::CMD_READ,  8'hFE, 8'h00, 1'b1, 1,   1'b0, PINS_IDLE},
        '{twrsm_pkg::CMD_TICK,  8'h00, 8'h00, 1'b0, 102, 1'b0, PINS_IDLE},
        '{twrsm_pkg::CMD_WRITE, 8'h01, 8'hFF, 1'b1, 1,   1'b0, PINS_IDLE},
        '{twrsm_pkg::CMD_TICK,  8'h00, 8'h00, 1'b1, 310, 1'b0, PINS_IDLE}
    };

    initial begin
        int r, k;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // default registers: phase 2, wrapped writes, exact back-to-back requests
        for (r = 0; r < 11; r++)
            for (k = 0; k < dir_rows[r].reps; k++)
                send(dir_rows[r].cmd, dir_rows[r].addr, dir_rows[r].wb, dir_rows[r].pin,
                     dir_rows[r].typed, dir_rows[r].exp);

        set_config(16'd1, 1'b1, twrsm_pkg::RST_CTRL_ADDR);
        random_accesses(60);
        set_config(16'd1, 1'b0, 8'hFF);
        random_accesses(40);
        set_config(16'd0, 1'b1, 8'h00);
        random_accesses(40);
        set_config(16'd3, 1'b0, pick_byte());
        random_accesses(40);

        // slowest phase setting, then shortened mid-access with the wrap turned off
        set_config(16'hFFFF, 1'b1, twrsm_pkg::RST_CTRL_ADDR);
        send(twrsm_pkg::CMD_WRITE, pick_byte(), pick_byte(), 1'b0, 1'b0, PINS_IDLE);
        send_ticks(100);
        set_config(16'd1, 1'b0, 8'h00);
        send_ticks(60);
        set_config(16'd1, 1'b1, 8'hFF);
        random_accesses(40);
        set_config(16'd2, 1'($urandom_range(0, 1)), pick_byte());
        random_accesses(40);

        drain();
        repeat (16) @(posedge i_clk);
        $display("ran %0d input beats and %0d result beats over 9 register settings",
                 n_items, n_results);
        $display("accesses: %0d writes, %0d reads, %0d completed, %0d refused while busy",
                 n_writes, n_reads, n_done, n_refused);
        if (err_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial begin
        #12000000;
        $display("status: fail");
        $finish;
    end

endmodule

FILE: sim.f
+incdir+rtl/core
rtl/core/twrsm_pkg.sv
rtl/core/three_wire_rtc_serial_master.sv
rtl/core/twrsm_checker.sv
test/three_wire_rtc_serial_master_tb.sv
